### rtl/rvp_pkg.sv
// package: payload types, register indexes and fixed widths for the radial vignette block
package rvp_pkg;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    localparam int DIM_W   = 13;
    localparam int QUO_W   = 32;
    localparam int ROOT_W  = 17;
    localparam logic [ROOT_W-1:0] ONE_Q16 = 17'h10000;

    typedef struct packed {
        logic [7:0]  in_red;
        logic [7:0]  in_green;
        logic [7:0]  in_blue;
        logic [11:0] pixel_row;
        logic [11:0] pixel_column;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } pix_out_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

endpackage

### rtl/rvp_div_cell.sv
// one restoring division step: rem and quotient move on to the next cell each cycle that en is high
module rvp_div_cell #(
    parameter int REM_W = 27
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      valid,
    input  logic [REM_W-1:0]          rem,
    input  logic [REM_W-1:0]          divisor,
    input  logic [rvp_pkg::QUO_W-1:0] quo,
    input  logic                      sat,
    input  rvp_pkg::rgb_t             rgb,
    output logic                      valid_q,
    output logic [REM_W-1:0]          rem_q,
    output logic [REM_W-1:0]          divisor_q,
    output logic [rvp_pkg::QUO_W-1:0] quo_q,
    output logic                      sat_q,
    output rvp_pkg::rgb_t             rgb_q
);
    logic [REM_W:0] sh;
    logic           ge;

    assign sh = {rem, 1'b0};
    assign ge = sh >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_q <= 1'b0;
        end
        else if (en)
        begin
            valid_q <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_q     <= ge ? REM_W'(sh - {1'b0, divisor}) : REM_W'(sh);
            divisor_q <= divisor;
            quo_q     <= {quo[rvp_pkg::QUO_W-2:0], ge};
            sat_q     <= sat;
            rgb_q     <= rgb;
        end
    end
endmodule

### rtl/rvp_sqrt_cell.sv
// one square root step: one result bit per cell, partial values handed to the next cell
module rvp_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      valid,
    input  logic [rvp_pkg::QUO_W-1:0] x,
    input  logic [rvp_pkg::QUO_W-1:0] res,
    input  logic                      sat,
    input  rvp_pkg::rgb_t             rgb,
    output logic                      valid_q,
    output logic [rvp_pkg::QUO_W-1:0] x_q,
    output logic [rvp_pkg::QUO_W-1:0] res_q,
    output logic                      sat_q,
    output rvp_pkg::rgb_t             rgb_q
);
    localparam logic [rvp_pkg::QUO_W-1:0] BIT = rvp_pkg::QUO_W'(1) << (30 - 2 * STEP);

    logic [rvp_pkg::QUO_W:0] trial;
    logic                    ge;

    assign trial = {1'b0, res} + {1'b0, BIT};
    assign ge    = {1'b0, x} >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_q <= 1'b0;
        end
        else if (en)
        begin
            valid_q <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_q   <= ge ? rvp_pkg::QUO_W'({1'b0, x} - trial) : x;
            res_q <= ge ? (res >> 1) + BIT : res >> 1;
            sat_q <= sat;
            rgb_q <= rgb;
        end
    end
endmodule

### rtl/radial_vignette_pixel.sv
// top level: radial vignette pipeline, offsets, divide chain, root chain, factor and scale
// Takes one pixel per clock and gives one result per clock while not stalled, in order:
// the offset and square registers form the squared offsets, 32 divide cells give one
// quotient bit each, 16 root cells give one root bit each, then g_reg and f_reg form the
// factor and the product and output registers the channel products (the factor square
// and the channel multiplies are split over registers). in_stall is high only while the
// output register is full and stalled, since the whole pipeline advances together; a stall
// therefore holds every stage. Widths are sized for MAX_DIM; dimension registers are
// saturated to 1..MAX_DIM on use.
module radial_vignette_pixel #(
    parameter int MAX_DIM = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  rvp_pkg::pix_in_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output rvp_pkg::pix_out_t                out_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rvp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rvp_pkg::DIM_W-1:0]        cfg_data
);
    localparam int DW     = $clog2(MAX_DIM + 1);
    localparam int PIX2_W = 13;
    localparam int OFF_W  = 1 + ((DW > PIX2_W) ? DW : PIX2_W);
    localparam int SQ_W   = 2 * (OFF_W - 1) + 1;
    localparam int NDIV   = rvp_pkg::QUO_W;
    localparam int NSQ    = 16;

    logic [rvp_pkg::DIM_W-1:0] width_reg, height_reg;
    logic                      run;

    assign cfg_ready = 1'b1;
    assign run       = !(out_valid && out_stall);
    assign in_stall  = !run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rvp_pkg::DIM_W'(640);
            height_reg <= rvp_pkg::DIM_W'(480);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rvp_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                rvp_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic logic [DW-1:0] sat_dim(input logic [rvp_pkg::DIM_W-1:0] v);
        logic [31:0] vv;
        vv = 32'(v);
        if (vv == 32'd0) return DW'(1);
        if (vv > 32'(MAX_DIM)) return DW'(MAX_DIM);
        return DW'(vv);
    endfunction

    logic [DW-1:0] w, h;
    assign w = sat_dim(width_reg);
    assign h = sat_dim(height_reg);

    // stage 1: doubled offsets
    logic                  v1_reg;
    logic signed [OFF_W-1:0] dx_reg, dy_reg;
    logic [DW-1:0]         w1_reg, h1_reg;
    rvp_pkg::rgb_t         c1_reg;
    // stage 2: squares
    logic                  v2_reg;
    logic [SQ_W-1:0]       s_reg, m_reg;
    rvp_pkg::rgb_t         c2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (run)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            dx_reg <= $signed(OFF_W'({in_data.pixel_column, 1'b0})) - $signed(OFF_W'(w));
            dy_reg <= $signed(OFF_W'({in_data.pixel_row, 1'b0})) - $signed(OFF_W'(h));
            w1_reg <= w;
            h1_reg <= h;
            c1_reg <= '{in_data.in_red, in_data.in_green, in_data.in_blue};
            s_reg  <= SQ_W'(dx_reg * dx_reg) + SQ_W'(dy_reg * dy_reg);
            m_reg  <= SQ_W'(w1_reg * w1_reg) + SQ_W'(h1_reg * h1_reg);
            c2_reg <= c1_reg;
        end
    end

    // divide chain
    logic                      dv  [NDIV+1];
    logic [SQ_W-1:0]           drem[NDIV+1];
    logic [SQ_W-1:0]           ddiv[NDIV+1];
    logic [rvp_pkg::QUO_W-1:0] dquo[NDIV+1];
    logic                      dsat[NDIV+1];
    rvp_pkg::rgb_t             dc  [NDIV+1];

    assign dv[0]   = v2_reg;
    assign drem[0] = s_reg;
    assign ddiv[0] = m_reg;
    assign dquo[0] = '0;
    assign dsat[0] = s_reg >= m_reg;
    assign dc[0]   = c2_reg;

    for (genvar i = 0; i < NDIV; i++)
    begin : g_div
        logic                      vq, sq;
        logic [SQ_W-1:0]           rq, dq;
        logic [rvp_pkg::QUO_W-1:0] qq;
        rvp_pkg::rgb_t             cq;
        rvp_div_cell #(.REM_W(SQ_W)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(run), .valid(dv[i]), .rem(drem[i]),
            .divisor(ddiv[i]), .quo(dquo[i]), .sat(dsat[i]), .rgb(dc[i]),
            .valid_q(vq), .rem_q(rq), .divisor_q(dq), .quo_q(qq), .sat_q(sq), .rgb_q(cq)
        );
        assign dv[i+1]   = vq;
        assign drem[i+1] = rq;
        assign ddiv[i+1] = dq;
        assign dquo[i+1] = qq;
        assign dsat[i+1] = sq;
        assign dc[i+1]   = cq;
    end

    // root chain
    logic                      qv  [NSQ+1];
    logic [rvp_pkg::QUO_W-1:0] qx  [NSQ+1];
    logic [rvp_pkg::QUO_W-1:0] qr  [NSQ+1];
    logic                      qs  [NSQ+1];
    rvp_pkg::rgb_t             qc  [NSQ+1];

    assign qv[0] = dv[NDIV];
    assign qx[0] = dquo[NDIV];
    assign qr[0] = '0;
    assign qs[0] = dsat[NDIV];
    assign qc[0] = dc[NDIV];

    for (genvar j = 0; j < NSQ; j++)
    begin : g_sqrt
        logic                      vq, sq;
        logic [rvp_pkg::QUO_W-1:0] xq, rq;
        rvp_pkg::rgb_t             cq;
        rvp_sqrt_cell #(.STEP(j)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(run), .valid(qv[j]), .x(qx[j]), .res(qr[j]),
            .sat(qs[j]), .rgb(qc[j]),
            .valid_q(vq), .x_q(xq), .res_q(rq), .sat_q(sq), .rgb_q(cq)
        );
        assign qv[j+1] = vq;
        assign qx[j+1] = xq;
        assign qr[j+1] = rq;
        assign qs[j+1] = sq;
        assign qc[j+1] = cq;
    end

    // factor and scaling
    logic                        v3_reg, v4_reg, v5_reg, v6_reg;
    logic [rvp_pkg::ROOT_W-1:0]  g_reg;
    logic [rvp_pkg::ROOT_W-1:0]  f_reg;
    rvp_pkg::rgb_t               c3_reg, c4_reg;
    logic [24:0]                 pr_reg, pg_reg, pb_reg;
    logic [2*rvp_pkg::ROOT_W-1:0] gg;
    logic [rvp_pkg::ROOT_W-1:0]  rr;

    assign rr = (qs[NSQ]) ? rvp_pkg::ONE_Q16 : rvp_pkg::ROOT_W'(qr[NSQ]);
    assign gg = g_reg * g_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            v6_reg    <= 1'b0;
        end
        else if (run)
        begin
            v3_reg    <= qv[NSQ];
            v4_reg    <= v3_reg;
            v5_reg    <= v4_reg;
            v6_reg    <= v5_reg;
        end
    end

    assign out_valid = v6_reg;

    always_ff @(posedge clk)
    begin
        if (run)
        begin
            g_reg    <= rvp_pkg::ONE_Q16 - rr;
            c3_reg   <= qc[NSQ];
            f_reg    <= rvp_pkg::ROOT_W'(gg >> 16);
            c4_reg   <= c3_reg;
            pr_reg   <= 25'(c4_reg.red * f_reg);
            pg_reg   <= 25'(c4_reg.green * f_reg);
            pb_reg   <= 25'(c4_reg.blue * f_reg);
            out_data <= '{pr_reg[23:16], pg_reg[23:16], pb_reg[23:16]};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) out_valid && out_stall |-> in_stall)
        else $error("input taken while output stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n) !run |=> $stable(v3_reg))
        else $error("pipeline moved during stall");
endmodule

### tb/tb_radial_vignette_pixel.sv
// testbench: radial vignette pixel block, directed table then random pixels checked by a predictor
`timescale 1ns / 1ps

module tb_radial_vignette_pixel;

    localparam int LATENCY = 54;

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] row;
        logic [11:0] col;
        bit          known;
        logic [7:0]  exp_r;
        logic [7:0]  exp_g;
        logic [7:0]  exp_b;
    } dir_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    rvp_pkg::pix_in_t  in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    rvp_pkg::pix_out_t out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [rvp_pkg::CFG_IDX_W-1:0] cfg_index = rvp_pkg::REG_IMAGE_WIDTH;
    logic [rvp_pkg::DIM_W-1:0]     cfg_data = '0;

    logic [rvp_pkg::DIM_W-1:0] width_reg;
    logic [rvp_pkg::DIM_W-1:0] height_reg;
    rvp_pkg::pix_out_t shaded_q[$];
    int                errors = 0;
    int                checked = 0;
    bit                calm = 1'b0;

    always #10 clk = ~clk;

    radial_vignette_pixel i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    function automatic logic [63:0] clamp_dim(logic [rvp_pkg::DIM_W-1:0] v);
        if (v == 0)
            return 64'd1;
        if (v > 4096)
            return 64'd4096;
        return 64'(v);
    endfunction

    function automatic logic [31:0] int_root(logic [31:0] x);
        logic [31:0] res;
        logic [31:0] bitv;
        res = 0;
        bitv = 32'h4000_0000;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic rvp_pkg::pix_out_t vignette(rvp_pkg::pix_in_t p);
        longint w, h, dx, dy, s, m, r, f, rem, q;
        rvp_pkg::pix_out_t o;
        w = longint'(clamp_dim(width_reg));
        h = longint'(clamp_dim(height_reg));
        dx = 2 * longint'(p.pixel_column) - w;
        dy = 2 * longint'(p.pixel_row) - h;
        s = dx * dx + dy * dy;
        m = w * w + h * h;
        if (s >= m)
            r = 65536;
        else
        begin
            rem = s;
            q = 0;
            for (int i = 0; i < 32; i++)
            begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= m)
                begin
                    rem -= m;
                    q |= 1;
                end
            end
            r = longint'(int_root(q[31:0]));
            if (r > 65536)
                r = 65536;
        end
        f = ((65536 - r) * (65536 - r)) >> 16;
        o.out_red   = 8'((longint'(p.in_red) * f) >> 16);
        o.out_green = 8'((longint'(p.in_green) * f) >> 16);
        o.out_blue  = 8'((longint'(p.in_blue) * f) >> 16);
        return o;
    endfunction

    task automatic write_reg(logic [rvp_pkg::CFG_IDX_W-1:0] idx,
                             logic [rvp_pkg::DIM_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == rvp_pkg::REG_IMAGE_WIDTH)
            width_reg = val;
        else
            height_reg = val;
        @(posedge clk);
    endtask

    task automatic send_pixel(rvp_pkg::pix_in_t p, bit known, rvp_pkg::pix_out_t exp_v);
        rvp_pkg::pix_out_t pred;
        while (!calm && $urandom_range(99) < 28)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        pred = vignette(p);
        if (known && pred !== exp_v)
        begin
            $display("%0t table row disagrees: expected %h actual %h", $time, exp_v, pred);
            errors++;
        end
        in_valid <= 1'b1;
        in_data  <= p;
        shaded_q.push_back(known ? exp_v : pred);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (shaded_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (shaded_q.size() == 0)
            begin
                $display("%0t unexpected beat: actual %h", $time, out_data);
                errors++;
            end
            else
            begin
                rvp_pkg::pix_out_t e;
                e = shaded_q.pop_front();
                checked++;
                if (out_data.out_red !== e.out_red)
                begin
                    $display("%0t red: expected %h actual %h", $time, e.out_red,
                             out_data.out_red);
                    errors++;
                end
                if (out_data.out_green !== e.out_green)
                begin
                    $display("%0t green: expected %h actual %h", $time, e.out_green,
                             out_data.out_green);
                    errors++;
                end
                if (out_data.out_blue !== e.out_blue)
                begin
                    $display("%0t blue: expected %h actual %h", $time, e.out_blue,
                             out_data.out_blue);
                    errors++;
                end
            end
        end
        out_stall <= (!calm && $urandom_range(99) < 28);
    end

    function automatic rvp_pkg::pix_in_t rand_pixel(int wmax, int hmax);
        rvp_pkg::pix_in_t p;
        p.in_red = 8'($urandom);
        p.in_green = 8'($urandom);
        p.in_blue = 8'($urandom);
        if ($urandom_range(9) == 0)
        begin
            p.pixel_row = 12'($urandom);
            p.pixel_column = 12'($urandom);
        end
        else
        begin
            p.pixel_row = 12'($urandom_range(hmax - 1));
            p.pixel_column = 12'($urandom_range(wmax - 1));
        end
        return p;
    endfunction

    initial
    begin
        dir_row_t tbl[$];
        rvp_pkg::pix_in_t p;
        rvp_pkg::pix_out_t e;
        int w, h;
        width_reg = 13'd640;
        height_reg = 13'd480;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // centre passes through, corner and outside go dark
        tbl.push_back('{8'hff, 8'h80, 8'h01, 12'd240, 12'd320, 1, 8'hff, 8'h80, 8'h01});
        tbl.push_back('{8'hff, 8'hff, 8'hff, 12'd0, 12'd0, 1, 8'h00, 8'h00, 8'h00});
        tbl.push_back('{8'hff, 8'hff, 8'hff, 12'd480, 12'd640, 1, 8'h00, 8'h00, 8'h00});
        tbl.push_back('{8'hff, 8'hff, 8'hff, 12'hfff, 12'hfff, 1, 8'h00, 8'h00, 8'h00});
        tbl.push_back('{8'h00, 8'h00, 8'h00, 12'd240, 12'd320, 1, 8'h00, 8'h00, 8'h00});
        tbl.push_back('{8'hff, 8'hff, 8'hff, 12'd479, 12'd639, 0, 0, 0, 0});
        tbl.push_back('{8'haa, 8'h55, 8'hff, 12'd100, 12'd500, 0, 0, 0, 0});
        tbl.push_back('{8'h55, 8'haa, 8'h7f, 12'd240, 12'd0, 0, 0, 0, 0});
        tbl.push_back('{8'hff, 8'hff, 8'hff, 12'd0, 12'd320, 0, 0, 0, 0});
        tbl.push_back('{8'h80, 8'h7f, 8'hfe, 12'd300, 12'd330, 0, 0, 0, 0});
        foreach (tbl[i])
        begin
            p = '{tbl[i].red, tbl[i].green, tbl[i].blue, tbl[i].row, tbl[i].col};
            e = '{tbl[i].exp_r, tbl[i].exp_g, tbl[i].exp_b};
            send_pixel(p, tbl[i].known, e);
        end
        drain();

        // smallest and largest dimensions, zero and oversized values saturate
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin w = 1; h = 1; end
                1: begin w = 0; h = 8191; end
                2: begin w = 4096; h = 4096; end
                3: begin w = 5000; h = 2; end
                default: begin w = $urandom_range(1, 4096); h = $urandom_range(1, 4096); end
            endcase
            write_reg(rvp_pkg::REG_IMAGE_WIDTH, rvp_pkg::DIM_W'(w));
            write_reg(rvp_pkg::REG_IMAGE_HEIGHT, rvp_pkg::DIM_W'(h));
            calm = (ph == 2);
            for (int k = 0; k < 100; k++)
            begin
                e = '0;
                send_pixel(rand_pixel(int'(clamp_dim(width_reg)),
                                      int'(clamp_dim(height_reg))), 0, e);
                if (k == 50)
                    drain();
            end
            calm = 1'b0;
            drain();
        end

        $display("covered centre, corner and outside pixels, %0d results over six sizes",
                 checked);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

### sim.f
rtl/rvp_pkg.sv
rtl/rvp_div_cell.sv
rtl/rvp_sqrt_cell.sv
rtl/radial_vignette_pixel.sv
tb/tb_radial_vignette_pixel.sv
